@@ rtl/rpf_pkg.sv @@
`default_nettype none
package rpf_pkg;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_END   = 2'd2
  } op_t;

  // Work kinds handed from front to back
  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,  // one byte, marked last
    KIND_ESC    = 2'd1,  // escape byte, then the stored byte
    KIND_END    = 2'd2   // '#', then checksum high and low hex digits
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;  // byte to send, or checksum for an end request
  } cmd_t;

  localparam logic [7:0] CHR_START  = 8'h24;  // '$'
  localparam logic [7:0] CHR_END    = 8'h23;  // '#'
  localparam logic [7:0] CHR_ESC    = 8'h7d;  // '}'
  localparam logic [7:0] CHR_STAR   = 8'h2a;  // '*'
  localparam logic [7:0] ESC_XOR    = 8'h20;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Step index within one request on the back side
  localparam logic [1:0] STEP_FIRST  = 2'd0;
  localparam logic [1:0] STEP_SECOND = 2'd1;
  localparam logic [1:0] STEP_THIRD  = 2'd2;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h57 + {4'd0, nib};  // 'a' - 10
    end
    return r;
  endfunction

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == CHR_END) || (b == CHR_START) || (b == CHR_ESC) || (b == CHR_STAR);
  endfunction

endpackage
`default_nettype wire

@@ rtl/rpf_front.sv @@
`default_nettype none
module rpf_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  output logic                 full,
  input  wire  [1:0]           in_operation,
  input  wire  [7:0]           in_data_byte,
  input  wire                  q_full,
  output logic                 q_push,
  output rpf_pkg::cmd_t        q_wdata
);

  logic [7:0] csum_r;
  logic [7:0] csum_nxt;
  logic       accept;
  logic [7:0] esc_byte;

  assign full     = q_full;
  assign accept   = push && !q_full;
  assign esc_byte = in_data_byte ^ rpf_pkg::ESC_XOR;

  // Classify the request, track the checksum in request order
  always_comb begin
    csum_nxt       = csum_r;
    q_push         = 1'b0;
    q_wdata.kind   = rpf_pkg::KIND_SINGLE;
    q_wdata.data   = in_data_byte;
    case (rpf_pkg::op_t'(in_operation))
      rpf_pkg::OP_START: begin
        q_push       = accept;
        q_wdata.data = rpf_pkg::CHR_START;
        if (accept) csum_nxt = 8'd0;
      end
      rpf_pkg::OP_DATA: begin
        q_push = accept;
        if (rpf_pkg::needs_escape(in_data_byte)) begin
          q_wdata.kind = rpf_pkg::KIND_ESC;
          q_wdata.data = esc_byte;
          if (accept) csum_nxt = csum_r + rpf_pkg::CHR_ESC + esc_byte;
        end else begin
          if (accept) csum_nxt = csum_r + in_data_byte;
        end
      end
      rpf_pkg::OP_END: begin
        q_push       = accept;
        q_wdata.kind = rpf_pkg::KIND_END;
        q_wdata.data = csum_r;
      end
      default: begin
        // unused operation: drop
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csum_r <= 8'd0;
    end else begin
      csum_r <= csum_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/rpf_queue.sv @@
`default_nettype none
module rpf_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_push,
  input  wire rpf_pkg::cmd_t   q_wdata,
  output logic                 q_full,
  input  wire                  q_pop,
  output logic                 q_empty,
  output rpf_pkg::cmd_t        q_head
);

  rpf_pkg::cmd_t                mem_r [rpf_pkg::QDEPTH];
  logic [rpf_pkg::QAW-1:0]      wptr_r;
  logic [rpf_pkg::QAW-1:0]      rptr_r;
  logic [rpf_pkg::QAW:0]        cnt_r;
  logic                         do_push;
  logic                         do_pop;

  assign q_full  = (cnt_r == (rpf_pkg::QAW+1)'(rpf_pkg::QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_head  = mem_r[rptr_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= q_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/rpf_back.sv @@
`default_nettype none
module rpf_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_empty,
  input  wire rpf_pkg::cmd_t   q_head,
  output logic                 q_pop,
  output logic                 empty,
  input  wire                  pop,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  logic [1:0] step_r;
  logic [1:0] step_nxt;
  logic       ovld_r;
  logic       ovld_nxt;
  logic [7:0] obyte_r;
  logic       olast_r;
  logic [7:0] sel_byte;
  logic       sel_last;
  logic       advance;

  assign empty    = !ovld_r;
  assign out_byte = obyte_r;
  assign out_last = olast_r;
  assign advance  = (!ovld_r || pop) && !q_empty;

  // Pick the byte for the current step of the head request
  always_comb begin
    sel_byte = q_head.data;
    sel_last = 1'b1;
    case (q_head.kind)
      rpf_pkg::KIND_SINGLE: begin
        sel_byte = q_head.data;
        sel_last = 1'b1;
      end
      rpf_pkg::KIND_ESC: begin
        sel_last = (step_r == rpf_pkg::STEP_SECOND);
        sel_byte = sel_last ? q_head.data : rpf_pkg::CHR_ESC;
      end
      rpf_pkg::KIND_END: begin
        sel_last = (step_r == rpf_pkg::STEP_THIRD);
        if (step_r == rpf_pkg::STEP_FIRST) begin
          sel_byte = rpf_pkg::CHR_END;
        end else if (step_r == rpf_pkg::STEP_SECOND) begin
          sel_byte = rpf_pkg::hex_digit(q_head.data[7:4]);
        end else begin
          sel_byte = rpf_pkg::hex_digit(q_head.data[3:0]);
        end
      end
      default: begin
        sel_byte = q_head.data;
        sel_last = 1'b1;
      end
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    ovld_nxt = ovld_r;
    q_pop    = 1'b0;
    if (advance) begin
      ovld_nxt = 1'b1;
      q_pop    = sel_last;
      step_nxt = sel_last ? rpf_pkg::STEP_FIRST : step_r + 1'b1;
    end else if (pop) begin
      ovld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= rpf_pkg::STEP_FIRST;
      ovld_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      obyte_r <= sel_byte;
      olast_r <= sel_last;
    end
  end

  // A request in progress stays at the queue head
  a_step_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != rpf_pkg::STEP_FIRST) |-> !q_empty)
    else $error("step in progress with empty queue");

  // Third step only exists for end requests
  a_third_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == rpf_pkg::STEP_THIRD) |-> (q_head.kind == rpf_pkg::KIND_END))
    else $error("third step on a non-end request");

  // Dequeue only while loading the final byte of a request into the output
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (ovld_r && olast_r))
    else $error("queue popped without a last byte loaded");

endmodule
`default_nettype wire

@@ rtl/rsp_packet_framer.sv @@
// Channel  | Ports                                  | Handshake
// ---------+----------------------------------------+------------------------------
// request  | in_operation[1:0], in_data_byte[7:0]   | taken when push && !full
// result   | out_byte[7:0], out_last                | taken when pop && !empty
//
// One framed byte leaves per cycle while the receiver pops and the queue holds
// work; a request becomes 1 to 3 link bytes (start/plain byte 1, escaped byte
// 2, end 3), each sent from the back-end serializer's single output register.
// A request reaches out_byte through the command queue and then the output register.
// Reset (rst_n low, synchronous) clears the checksum, the queue and the output.
// A stalled result side fills the 4-entry command queue before full rises.
`default_nettype none
module rsp_packet_framer (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        push,
  output logic       full,
  input  wire  [1:0] in_operation,
  input  wire  [7:0] in_data_byte,
  output logic       empty,
  input  wire        pop,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  rpf_pkg::cmd_t q_wdata;
  rpf_pkg::cmd_t q_head;

  // Front: classify requests, escape bytes, keep the running checksum
  rpf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_operation (in_operation),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  // Command queue: decouple request acceptance from byte emission
  rpf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  // Back: serialize each command into link bytes, one per cycle while the receiver pops
  rpf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule
`default_nettype wire

@@ dv/rsp_packet_framer_tb.sv @@
`default_nettype none
module rsp_packet_framer_tb;
  import rpf_pkg::*;

  // Operation code that the framer drops without output
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Receiver stall styles
  typedef enum logic [1:0] {
    RX_ALWAYS  = 2'd0,
    RX_RANDOM  = 2'd1,
    RX_PATTERN = 2'd2
  } rx_style_t;

  // One framed byte as it should appear on the link
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } link_byte_t;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [1:0] in_operation;
  logic [7:0] in_data_byte;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       out_last;

  rsp_packet_framer dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_operation (in_operation),
    .in_data_byte (in_data_byte),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  // Predicted link bytes, oldest first, and the predictor's own checksum
  link_byte_t link_expected[$];
  logic [7:0] pkt_sum;
  int         fail_count;

  // Sender burst state
  int burst_left;
  bit tx_steady;

  // Receiver state: stall style, its mask, a long hold-off counter
  rx_style_t  rx_style;
  bit         rx_lock;
  logic [7:0] rx_mask;
  int         rx_phase;
  int         rx_holdoff;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: far above the slowest legal run (every request at three bytes,
  // every byte waiting out the worst receiver stall, plus the long hold-off)
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    return (nib < 4'd10) ? ("0" + {4'd0, nib}) : ("a" - 8'd10 + {4'd0, nib});
  endfunction

  function automatic bit is_special(input logic [7:0] b);
    return b == CHR_END || b == CHR_START || b == CHR_ESC || b == CHR_STAR;
  endfunction

  function automatic void expect_link(input logic [7:0] data, input logic last);
    link_byte_t lb;
    lb.data = data;
    lb.last = last;
    link_expected.push_back(lb);
  endfunction

  // Work out the link bytes for one accepted request and advance the checksum
  function automatic void frame_request(input logic [1:0] op, input logic [7:0] data);
    logic [7:0] flipped;
    case (op)
      OP_START: begin
        pkt_sum = 8'd0;
        expect_link(CHR_START, 1'b1);
      end
      OP_DATA: begin
        if (is_special(data)) begin
          flipped = data ^ ESC_XOR;
          pkt_sum = pkt_sum + CHR_ESC + flipped;
          expect_link(CHR_ESC, 1'b0);
          expect_link(flipped, 1'b1);
        end else begin
          pkt_sum = pkt_sum + data;
          expect_link(data, 1'b1);
        end
      end
      OP_END: begin
        // checksum is sent, not cleared
        expect_link(CHR_END, 1'b0);
        expect_link(ascii_hex(pkt_sum[7:4]), 1'b0);
        expect_link(ascii_hex(pkt_sum[3:0]), 1'b1);
      end
      default: ;  // unused code: nothing on the link, checksum untouched
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking: sample both handshakes at the rising edge
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s mismatch: expected %02h, got %02h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    link_byte_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        if (link_expected.size() == 0) begin
          report_mismatch("unexpected byte", 8'h00, out_byte);
        end else begin
          want = link_expected.pop_front();
          if (out_byte !== want.data)
            report_mismatch("out_byte", want.data, out_byte);
          if (out_last !== want.last)
            report_mismatch("out_last", {7'd0, want.last}, {7'd0, out_last});
        end
      end
      if (push && !full)
        frame_request(in_operation, in_data_byte);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: drive pop at the falling edge
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    rx_phase++;
    // Re-pick the stall style now and then unless a test holds it
    if (!rx_lock && rx_phase % 64 == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 2));
      rx_mask  = 8'($urandom_range(1, 255));
    end
    if (rx_holdoff > 0) begin
      // hold off entirely; the sender keeps pushing until full rises
      pop = 1'b0;
      rx_holdoff--;
    end else begin
      case (rx_style)
        RX_ALWAYS: pop = 1'b1;
        RX_RANDOM: pop = ($urandom_range(0, 3) != 0);
        default: begin
          pop     = rx_mask[0];
          rx_mask = {rx_mask[0], rx_mask[7:1]};
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one request and hold it until taken. Entered and left just after a
  // falling edge; push stays high on exit so a burst runs back to back.
  task automatic send_request(input logic [1:0] op, input logic [7:0] data);
    bit taken;
    if (burst_left == 0) begin
      if (!tx_steady) begin
        push = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    push         = 1'b1;
    in_operation = op;
    in_data_byte = data;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !full;
    end
    burst_left--;
    @(negedge clk);
  endtask

  // Drop push and wait for every predicted byte to leave
  task automatic drain_link();
    push       = 1'b0;
    burst_left = 0;
    while (link_expected.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 7))
      0: return CHR_END;
      1: return CHR_START;
      2: return CHR_ESC;
      3: return CHR_STAR;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Payload and end before any start: checksum builds from its reset value
  task automatic test_no_start();
    send_request(OP_DATA, 8'h41);
    send_request(OP_DATA, CHR_END);
    send_request(OP_END, 8'h00);
    send_request(OP_END, 8'hff);       // repeated end resends the same sum
    send_request(OP_UNUSED, 8'hff);
    drain_link();
  endtask

  // Field extremes, every escape byte, ignored bytes on start and end
  task automatic test_directed_frames();
    send_request(OP_START, 8'hff);
    send_request(OP_DATA, 8'h00);
    send_request(OP_DATA, 8'hff);
    send_request(OP_DATA, CHR_END);
    send_request(OP_DATA, CHR_START);
    send_request(OP_DATA, CHR_ESC);
    send_request(OP_DATA, CHR_STAR);
    send_request(OP_DATA, 8'h7c);      // a neighbor of the escape byte passes plain
    send_request(OP_DATA, 8'h03);      // already-flipped form of '#'
    send_request(OP_END, 8'ha5);
    send_request(OP_UNUSED, 8'h00);
    send_request(OP_END, 8'h5a);
    send_request(OP_START, 8'h00);
    send_request(OP_DATA, 8'h80);
    send_request(OP_DATA, 8'h80);      // wrap the checksum
    send_request(OP_DATA, 8'h0a);
    send_request(OP_END, 8'h24);
    drain_link();
  endtask

  // Stop popping for a long stretch while pushing escape-heavy packets
  task automatic test_fill_and_stall();
    int i;
    push = 1'b0;
    burst_left = 0;
    @(posedge clk);
    rx_holdoff = 80;
    @(negedge clk);
    tx_steady = 1'b1;
    for (i = 0; i < 4; i++) begin
      send_request(OP_START, 8'($urandom_range(0, 255)));
      send_request(OP_DATA, CHR_ESC);
      send_request(OP_DATA, CHR_STAR);
      send_request(OP_DATA, 8'($urandom_range(0, 255)));
      send_request(OP_END, 8'($urandom_range(0, 255)));
    end
    tx_steady = 1'b0;
    drain_link();
  endtask

  // Mostly well-formed packets with random content, the rest noise
  task automatic test_random_packets(input int n_items);
    int sent;
    int len;
    int j;
    logic [1:0] op;
    sent = 0;
    while (sent < n_items) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 6) != 0) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
        send_request(OP_START, 8'($urandom_range(0, 255)));
        for (j = 0; j < len; j++) send_request(OP_DATA, pick_payload());
        sent += len + 1;
        // sometimes leave the packet open
        if ($urandom_range(0, 7) != 0) begin
          send_request(OP_END, 8'($urandom_range(0, 255)));
          sent++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          op = 2'($urandom_range(0, 3));
          send_request(op, pick_payload());
          if (op != OP_UNUSED) sent++;
        end
      end
    end
    tx_steady = 1'b0;
    drain_link();
  endtask

  // Full rate on both sides: no sender gaps, receiver always ready
  task automatic test_steady_stream();
    int i;
    rx_lock   = 1'b1;
    rx_style  = RX_ALWAYS;
    tx_steady = 1'b1;
    send_request(OP_START, 8'h00);
    for (i = 0; i < 28; i++) send_request(OP_DATA, pick_payload());
    send_request(OP_END, 8'h00);
    tx_steady = 1'b0;
    drain_link();
    rx_lock = 1'b0;
  endtask

  // Let any stray bytes surface, then give the verdict
  task automatic finish_run();
    drain_link();
    rx_lock  = 1'b1;
    rx_style = RX_ALWAYS;
    repeat (20) @(posedge clk);
    if (fail_count == 0 && link_expected.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  endtask

  initial begin
    rst_n        = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    in_operation = OP_START;
    in_data_byte = 8'h00;
    pkt_sum      = 8'd0;
    fail_count   = 0;
    burst_left   = 0;
    tx_steady    = 1'b0;
    rx_style     = RX_RANDOM;
    rx_lock      = 1'b0;
    rx_mask      = 8'hb5;
    rx_phase     = 0;
    rx_holdoff   = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_no_start();
    test_directed_frames();
    test_fill_and_stall();
    test_random_packets(380);
    test_steady_stream();
    finish_run();
  end

endmodule
`default_nettype wire

@@ rsp_packet_framer.f @@
rtl/rpf_pkg.sv
rtl/rpf_front.sv
rtl/rpf_queue.sv
rtl/rpf_back.sv
rtl/rsp_packet_framer.sv
dv/rsp_packet_framer_tb.sv
